// ===== hw/rtl/sum_pkg.sv =====
// Shared types and constants for the sorted union merge block.
package sum_pkg;

    localparam int LIST_DEPTH_DEF = 32;
    localparam int VALUE_W        = 32;

    localparam logic [1:0] REQ_LOAD_A = 2'd0;
    localparam logic [1:0] REQ_LOAD_B = 2'd1;
    localparam logic [1:0] REQ_RUN    = 2'd2;

    typedef struct packed {
        logic [1:0]                req_type;
        logic signed [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic signed [VALUE_W-1:0] union_value;
        logic                      last_of_run;
        logic                      union_empty;
        logic                      overflow;
    } t_result;

    typedef enum logic {
        ST_IDLE,
        ST_MERGE
    } t_state;

endpackage

// ===== hw/rtl/sum_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sum_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/sorted_union_merge.sv =====
// Sorted union merge: loads two ascending lists and emits their distinct union in order.
// A load (list A or list B) leaves the block idle, so the block stays ready for the next request.
// A run makes one comparison of the two list heads per cycle, each head read from its
// own list RAM, until both lists are used up, and then a closing step. Results appear
// on o_result for one cycle each, flagged by o_strobe, at most one per cycle; the
// final one carries last_of_run.
// Results cannot be held off, so the receiver must take every strobed beat.
// An empty union gives a single beat with union_empty set. A run clears both lists
// and the overflow flag.
module sorted_union_merge #(
    parameter int LIST_DEPTH = sum_pkg::LIST_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  sum_pkg::t_req    i_req,
    output logic             o_strobe,
    output sum_pkg::t_result o_result
);
    import sum_pkg::*;

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);

    t_state              r_state, n_state;
    logic [CW-1:0]       r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [CW-1:0]       r_i, n_i, r_j, n_j;
    logic                r_drop, n_drop;
    logic                r_have, n_have;
    logic [VALUE_W-1:0]  r_prev, n_prev;
    logic                r_strobe, n_strobe;
    t_result             r_out, n_out;

    logic                w_accept;
    logic                we_a, we_b;
    logic [VALUE_W-1:0]  rd_a, rd_b;
    logic                a_ok, b_ok, take_a;
    logic [VALUE_W-1:0]  pick;

    assign w_accept = start && (r_state == ST_IDLE);
    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

    sum_ram #(.WIDTH(VALUE_W), .DEPTH(LIST_DEPTH), .AW(AW)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[AW-1:0]),
        .i_wdata (i_req.value),
        .i_raddr (n_i[AW-1:0]),
        .o_rdata (rd_a)
    );

    sum_ram #(.WIDTH(VALUE_W), .DEPTH(LIST_DEPTH), .AW(AW)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[AW-1:0]),
        .i_wdata (i_req.value),
        .i_raddr (n_j[AW-1:0]),
        .o_rdata (rd_b)
    );

    assign a_ok   = (r_i < r_cnt_a);
    assign b_ok   = (r_j < r_cnt_b);
    assign take_a = a_ok && (!b_ok || ($signed(rd_a) <= $signed(rd_b)));
    assign pick   = take_a ? rd_a : rd_b;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_req.req_type == REQ_RUN)) begin
                    n_state = ST_MERGE;
                end
            end
            ST_MERGE: begin
                if (!a_ok && !b_ok) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_cnt_a  = r_cnt_a;
        n_cnt_b  = r_cnt_b;
        n_i      = r_i;
        n_j      = r_j;
        n_drop   = r_drop;
        n_have   = r_have;
        n_prev   = r_prev;
        n_strobe = 1'b0;
        n_out    = r_out;
        we_a     = 1'b0;
        we_b     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_req.req_type)
                        REQ_LOAD_A: begin
                            if (r_cnt_a < CW'(LIST_DEPTH)) begin
                                we_a    = 1'b1;
                                n_cnt_a = r_cnt_a + CW'(1);
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                        REQ_LOAD_B: begin
                            if (r_cnt_b < CW'(LIST_DEPTH)) begin
                                we_b    = 1'b1;
                                n_cnt_b = r_cnt_b + CW'(1);
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                        REQ_RUN: begin
                            n_i    = '0;
                            n_j    = '0;
                            n_have = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MERGE: begin
                if (a_ok || b_ok) begin
                    if (take_a) begin
                        n_i = r_i + CW'(1);
                    end else begin
                        n_j = r_j + CW'(1);
                    end
                    if (!r_have || (pick != r_prev)) begin
                        // pending value is now known not to be the last
                        if (r_have) begin
                            n_strobe          = 1'b1;
                            n_out.union_value = r_prev;
                            n_out.last_of_run = 1'b0;
                            n_out.union_empty = 1'b0;
                            n_out.overflow    = r_drop;
                        end
                        n_prev = pick;
                        n_have = 1'b1;
                    end
                end else begin
                    n_strobe          = 1'b1;
                    n_out.union_value = r_have ? r_prev : '0;
                    n_out.last_of_run = 1'b1;
                    n_out.union_empty = !r_have;
                    n_out.overflow    = r_drop;
                    n_cnt_a           = '0;
                    n_cnt_b           = '0;
                    n_drop            = 1'b0;
                    n_i               = '0;
                    n_j               = '0;
                    n_have            = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt_a  <= '0;
            r_cnt_b  <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_drop   <= 1'b0;
            r_have   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt_a  <= n_cnt_a;
            r_cnt_b  <= n_cnt_b;
            r_i      <= n_i;
            r_j      <= n_j;
            r_drop   <= n_drop;
            r_have   <= n_have;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev <= n_prev;
        r_out  <= n_out;
    end

    a_idx_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_i <= r_cnt_a)
        else $error("list A index beyond fill count");

    a_idx_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_j <= r_cnt_b)
        else $error("list B index beyond fill count");

    a_end_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MERGE) && !a_ok && !b_ok |=> o_strobe && o_result.last_of_run)
        else $error("run ended without a last beat");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.union_empty |-> o_result.last_of_run)
        else $error("empty beat not marked last");

    a_beat_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == ST_MERGE))
        else $error("beat outside a run");

endmodule
